// ----- rtl/d2r_pkg.sv -----
// Shared types, table constants and lookup functions for the Roman numeral encoder.
`timescale 1ns / 1ps

package d2r_pkg;

  localparam int unsigned VALUE_W  = 12;
  localparam int unsigned SYMBOL_W = 8;
  localparam int unsigned IDX_W    = 4;

  localparam logic [VALUE_W-1:0] MAX_VALUE = 12'd3999;

  localparam logic [SYMBOL_W-1:0] CH_NONE = 8'h00;
  localparam logic [SYMBOL_W-1:0] CH_I    = 8'h49;
  localparam logic [SYMBOL_W-1:0] CH_V    = 8'h56;
  localparam logic [SYMBOL_W-1:0] CH_X    = 8'h58;
  localparam logic [SYMBOL_W-1:0] CH_L    = 8'h4C;
  localparam logic [SYMBOL_W-1:0] CH_C    = 8'h43;
  localparam logic [SYMBOL_W-1:0] CH_D    = 8'h44;
  localparam logic [SYMBOL_W-1:0] CH_M    = 8'h4D;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PAIR
  } state_t;

  // Result of one pass through the compare/subtract unit.
  typedef struct packed {
    logic                ge;
    logic                zero_after;
    logic                pair;
    logic [VALUE_W-1:0]  diff;
    logic [SYMBOL_W-1:0] first;
    logic [SYMBOL_W-1:0] second;
  } step_res_t;

  function automatic logic [VALUE_W-1:0] step_value(input logic [IDX_W-1:0] idx);
    logic [VALUE_W-1:0] v;
    unique case (idx)
      4'd0:    v = 12'd1000;
      4'd1:    v = 12'd900;
      4'd2:    v = 12'd500;
      4'd3:    v = 12'd400;
      4'd4:    v = 12'd100;
      4'd5:    v = 12'd90;
      4'd6:    v = 12'd50;
      4'd7:    v = 12'd40;
      4'd8:    v = 12'd10;
      4'd9:    v = 12'd9;
      4'd10:   v = 12'd5;
      4'd11:   v = 12'd4;
      default: v = 12'd1;
    endcase
    return v;
  endfunction

  function automatic logic [SYMBOL_W-1:0] step_first(input logic [IDX_W-1:0] idx);
    logic [SYMBOL_W-1:0] c;
    unique case (idx)
      4'd0:    c = CH_M;
      4'd1:    c = CH_C;
      4'd2:    c = CH_D;
      4'd3:    c = CH_C;
      4'd4:    c = CH_C;
      4'd5:    c = CH_X;
      4'd6:    c = CH_L;
      4'd7:    c = CH_X;
      4'd8:    c = CH_X;
      4'd9:    c = CH_I;
      4'd10:   c = CH_V;
      4'd11:   c = CH_I;
      default: c = CH_I;
    endcase
    return c;
  endfunction

  function automatic logic [SYMBOL_W-1:0] step_second(input logic [IDX_W-1:0] idx);
    logic [SYMBOL_W-1:0] c;
    unique case (idx)
      4'd1:    c = CH_M;
      4'd3:    c = CH_D;
      4'd5:    c = CH_C;
      4'd7:    c = CH_L;
      4'd9:    c = CH_X;
      4'd11:   c = CH_V;
      default: c = CH_NONE;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/d2r_step_unit.sv -----
// Shared compare/subtract unit: tests the remainder against one table entry.
`timescale 1ns / 1ps

module d2r_step_unit (
  input  logic [d2r_pkg::VALUE_W-1:0] rest,
  input  logic [d2r_pkg::IDX_W-1:0]   idx,
  output d2r_pkg::step_res_t          res
);
  import d2r_pkg::*;

  logic [VALUE_W:0]    sub;
  logic [SYMBOL_W-1:0] second;

  // One subtract gives both the compare (no borrow) and the new remainder.
  assign sub    = {1'b0, rest} - {1'b0, step_value(idx)};
  assign second = step_second(idx);

  always_comb begin
    res.ge         = ~sub[VALUE_W];
    res.diff       = sub[VALUE_W-1:0];
    res.zero_after = (sub[VALUE_W-1:0] == '0);
    res.pair       = (second != CH_NONE);
    res.first      = step_first(idx);
    res.second     = second;
  end

endmodule

// ----- rtl/decimal_to_roman_encoder.sv -----
// Top level: converts one binary integer into a stream of Roman numeral letters.
`timescale 1ns / 1ps

//  Channel | Ports                                      | Direction
//  --------+--------------------------------------------+----------
//  input   | in_valid, in_stall, in_value[11:0]         | word in
//  result  | out_valid, out_stall, out_symbol[7:0],     | word out
//          | out_last, out_out_of_range                 |
//
//  One compare/subtract unit walks the thirteen-entry greedy table, one decision per cycle
//  unless a letter waits on a full output register: emit a letter or advance to the next
//  entry. An accepted item holds the block until its last letter is issued; an out-of-range
//  value gives one error word. in_stall is also high while a stalled word sits in the output
//  register. Reset (rst_n low, synchronous) returns the sequencer to idle and drops any pending
//  word; out_stall holds letters and loses nothing.

module decimal_to_roman_encoder (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [d2r_pkg::VALUE_W-1:0]  in_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [d2r_pkg::SYMBOL_W-1:0] out_symbol,
  output logic                         out_last,
  output logic                         out_out_of_range
);
  import d2r_pkg::*;

  state_t              state_r, state_nxt;
  logic [VALUE_W-1:0]  rest_r, rest_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [SYMBOL_W-1:0] pend_r, pend_nxt;     // second letter of a subtractive pair

  logic                out_valid_r, out_valid_nxt;
  logic [SYMBOL_W-1:0] out_symbol_r, out_symbol_nxt;
  logic                out_last_r, out_last_nxt;
  logic                out_oor_r, out_oor_nxt;

  logic      slot_free;
  logic      in_acc;
  logic      bad_value;
  step_res_t step;

  d2r_step_unit u_step (
    .rest (rest_r),
    .idx  (idx_r),
    .res  (step)
  );

  // Output register can take a new word when empty or being drained this cycle.
  assign slot_free = ~out_valid_r | ~out_stall;
  assign in_stall  = (state_r != ST_IDLE) | ~slot_free;
  assign in_acc    = in_valid & ~in_stall;
  assign bad_value = (in_value == '0) | (in_value > MAX_VALUE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rest_r       <= rest_nxt;
    idx_r        <= idx_nxt;
    pend_r       <= pend_nxt;
    out_symbol_r <= out_symbol_nxt;
    out_last_r   <= out_last_nxt;
    out_oor_r    <= out_oor_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    rest_nxt       = rest_r;
    idx_nxt        = idx_r;
    pend_nxt       = pend_r;
    out_valid_nxt  = out_valid_r & out_stall;
    out_symbol_nxt = out_symbol_r;
    out_last_nxt   = out_last_r;
    out_oor_nxt    = out_oor_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (bad_value) begin
            // Single error word; the block stays idle.
            out_valid_nxt  = 1'b1;
            out_symbol_nxt = CH_NONE;
            out_last_nxt   = 1'b1;
            out_oor_nxt    = 1'b1;
          end else begin
            rest_nxt  = in_value;
            idx_nxt   = '0;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (!step.ge) begin
          // Entry too large: advance. Entry one always fits, so this stops in range.
          idx_nxt = idx_r + IDX_W'(1);
        end else if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_symbol_nxt = step.first;
          out_oor_nxt    = 1'b0;
          rest_nxt       = step.diff;
          if (step.pair) begin
            out_last_nxt = 1'b0;
            pend_nxt     = step.second;
            state_nxt    = ST_PAIR;
          end else begin
            out_last_nxt = step.zero_after;
            if (step.zero_after) begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      ST_PAIR: begin
        // Remainder was already reduced when the first letter went out.
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_symbol_nxt = pend_r;
          out_oor_nxt    = 1'b0;
          out_last_nxt   = (rest_r == '0);
          state_nxt      = (rest_r == '0) ? ST_IDLE : ST_SCAN;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_symbol       = out_symbol_r;
  assign out_last         = out_last_r;
  assign out_out_of_range = out_oor_r;

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for the Roman numeral encoder: random pacing, letter-by-letter check.
`timescale 1ns / 1ps

module testbench;

  import d2r_pkg::*;

  // Abort when this many cycles go by with no word moving on either channel.
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  // Extra cycles to watch for stray words once everything expected has arrived.
  localparam int unsigned DRAIN_CYCLES   = 40;
  localparam int unsigned RANDOM_VALUES  = 257;
  localparam int unsigned REPORT_LIMIT   = 10;

  // One expected or observed output word.
  typedef struct packed {
    logic [SYMBOL_W-1:0] symbol;
    logic                last;
    logic                out_of_range;
  } letter_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [VALUE_W-1:0]  in_value;
  logic                out_valid;
  logic                out_stall;
  logic [SYMBOL_W-1:0] out_symbol;
  logic                out_last;
  logic                out_out_of_range;

  decimal_to_roman_encoder u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_symbol       (out_symbol),
    .out_last         (out_last),
    .out_out_of_range (out_out_of_range)
  );

  // Greedy table, largest weight first; a tail of CH_NONE means a single letter.
  int unsigned         numeral_weight [13] = '{1000, 900, 500, 400, 100, 90, 50, 40,
                                               10, 9, 5, 4, 1};
  logic [SYMBOL_W-1:0] numeral_head   [13] = '{CH_M, CH_C, CH_D, CH_C, CH_C, CH_X, CH_L,
                                               CH_X, CH_X, CH_I, CH_V, CH_I, CH_I};
  logic [SYMBOL_W-1:0] numeral_tail   [13] = '{CH_NONE, CH_M, CH_NONE, CH_D, CH_NONE,
                                               CH_C, CH_NONE, CH_L, CH_NONE, CH_X,
                                               CH_NONE, CH_V, CH_NONE};

  logic [VALUE_W-1:0] pending_values [$];
  letter_t            expected_letters [$];

  // Handshake events of the last rising edge, read by the falling-edge drivers.
  logic in_fire;
  logic out_fire;

  logic        in_burst;
  logic        out_burst;
  int unsigned in_gap;
  int unsigned out_hold;

  int unsigned values_taken;
  int unsigned letters_checked;
  int unsigned range_errors_seen;
  int unsigned mismatch_count;
  int unsigned idle_cycles;
  logic        timed_out;

  // Clock: 10 ns period.
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Append one expected word at the tail of the queue.
  function automatic void queue_letter(input letter_t item);
    expected_letters = {expected_letters, item};
  endfunction

  // Spell one value the greedy way and queue its letters, marking the final one.
  // Zero and anything above the top of the range give a single flagged word.
  function automatic void encode_numeral(input logic [VALUE_W-1:0] value);
    logic [SYMBOL_W-1:0] spelled [16];
    int unsigned         rest;
    int                  n;
    int                  k;
    n    = 0;
    rest = 32'(value);
    if (value == '0 || value > MAX_VALUE) begin
      queue_letter({CH_NONE, 1'b1, 1'b1});
      return;
    end
    for (k = 0; k < 13; k++) begin
      while (rest >= numeral_weight[k]) begin
        spelled[n] = numeral_head[k];
        n++;
        if (numeral_tail[k] != CH_NONE) begin
          spelled[n] = numeral_tail[k];
          n++;
        end
        rest -= numeral_weight[k];
      end
    end
    for (k = 0; k < n; k++) begin
      queue_letter({spelled[k], k == n - 1, 1'b0});
    end
  endfunction

  // Draw a random wait length from 0 to 13; burst mode means no waiting at all.
  function automatic int unsigned draw_gap(input logic burst);
    if (burst) begin
      return 0;
    end
    return $urandom_range(0, 13);
  endfunction

  function automatic void note_mismatch(input string what, input letter_t want,
                                        input letter_t seen);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("%0t: %s: expected symbol %h last %b out_of_range %b,",
               $realtime, what, want.symbol, want.last, want.out_of_range,
               " got symbol %h last %b out_of_range %b",
               seen.symbol, seen.last, seen.out_of_range);
    end
  endfunction

  // Input driver: present one value at a time, hold it until taken, then
  // wait the drawn gap before loading the next one from the pending queue.
  always @(negedge clk) begin : drive_values
    logic present;
    present = in_valid && !in_fire;
    if (rst_n && !present) begin
      if (in_gap != 0) begin
        in_gap = in_gap - 1;
      end else if (pending_values.size() != 0) begin
        in_value <= pending_values.pop_front();
        present = 1'b1;
        if ($urandom_range(0, 19) == 0) begin
          in_burst = !in_burst;
        end
        in_gap = draw_gap(in_burst);
      end
    end
    in_valid <= present;
  end

  // Result receiver: after each word taken, hold off for a drawn number of cycles.
  always @(negedge clk) begin : drive_stall
    if (rst_n && out_fire) begin
      if ($urandom_range(0, 19) == 0) begin
        out_burst = !out_burst;
      end
      out_hold = draw_gap(out_burst);
    end
    if (out_hold != 0) begin
      out_hold = out_hold - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: predict on every accepted value, compare every accepted word
  // against the oldest expectation, and keep the watchdog running.
  always @(posedge clk) begin : check_letters
    letter_t seen;
    letter_t want;
    in_fire  = rst_n && in_valid && !in_stall;
    out_fire = rst_n && out_valid && !out_stall;
    if (in_fire) begin
      encode_numeral(in_value);
      values_taken++;
    end
    if (out_fire) begin
      seen = {out_symbol, out_last, out_out_of_range};
      if (expected_letters.size() == 0) begin
        note_mismatch("word with nothing expected", '0, seen);
      end else begin
        want = expected_letters.pop_front();
        if (seen !== want) begin
          note_mismatch("word mismatch", want, seen);
        end
        letters_checked++;
        if (seen.out_of_range === 1'b1) begin
          range_errors_seen++;
        end
      end
    end
    if (in_fire || out_fire) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        timed_out = 1'b1;
      end
    end
  end

  initial begin : run_stimulus
    logic [VALUE_W-1:0] value;
    int unsigned        pick;

    // Drive every input to a known level before the first edge.
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_value          = '0;
    out_stall         = 1'b0;
    in_fire           = 1'b0;
    out_fire          = 1'b0;
    in_burst          = 1'b0;
    out_burst         = 1'b0;
    in_gap            = 0;
    out_hold          = 0;
    values_taken      = 0;
    letters_checked   = 0;
    range_errors_seen = 0;
    mismatch_count    = 0;
    idle_cycles       = 0;
    timed_out         = 1'b0;

    // Directed: range ends, out-of-range values, every subtractive pair,
    // the longest numeral and alternating bit patterns.
    pending_values = '{12'd1, 12'd3999, 12'd0, 12'd4000, 12'd4095, 12'd3888,
                       12'd4, 12'd9, 12'd14, 12'd40, 12'd90, 12'd400, 12'd900,
                       12'd1994, 12'd2048, 12'd1000, 12'd500, 12'd49, 12'd444,
                       12'd2730, 12'd1365, 12'd3000, 12'd3};

    // Random: mostly legal values, a share of short numerals, some out of range.
    repeat (RANDOM_VALUES) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        value = ($urandom_range(0, 3) == 0) ? '0 : VALUE_W'($urandom_range(4000, 4095));
      end else if (pick < 25) begin
        value = VALUE_W'($urandom_range(1, 60));
      end else begin
        value = VALUE_W'($urandom_range(1, 3999));
      end
      pending_values = {pending_values, value};
    end

    // Hold reset, then release it on a falling edge, away from the sampling edge.
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Wait until every value is taken and every letter has come back.
    while (!timed_out && (pending_values.size() != 0 || in_valid
                          || expected_letters.size() != 0)) begin
      @(posedge clk);
    end
    if (!timed_out) begin
      repeat (DRAIN_CYCLES) @(posedge clk);
    end

    $display("summary: %0d values converted, %0d letters checked (%0d range errors)",
             values_taken, letters_checked, range_errors_seen);
    $display("summary: %0d mismatches, %0d letters still outstanding, watchdog %s",
             mismatch_count, expected_letters.size(), timed_out ? "expired" : "quiet");
    if (!timed_out && mismatch_count == 0 && expected_letters.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/d2r_pkg.sv
rtl/d2r_step_unit.sv
rtl/decimal_to_roman_encoder.sv
sim/testbench.sv
